@@ sv/dla_pkg.sv @@
// Shared types, limits, codes and helpers of the aggregation engine.
`default_nettype none
package dla_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_WALKERS   = 16384;
  localparam int COORD_LIMIT   = 1024;

  localparam int COORD_W       = 10;
  localparam int SIZE_W        = 11;
  localparam int IDX_W         = $clog2(MAX_WALKERS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int WORDS_PER_ROW = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
  localparam int WSEL_W        = $clog2(WORDS_PER_ROW);
  localparam int ROW_W         = $clog2(MAX_HEIGHT);
  localparam int MAP_WORDS     = WORDS_PER_ROW * MAX_HEIGHT;
  localparam int MAP_AW        = ROW_W + WSEL_W;
  localparam int ENTRY_W       = 2 * COORD_W;

  localparam int W_LIMIT = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
  localparam int H_LIMIT = (MAX_HEIGHT < COORD_LIMIT) ? MAX_HEIGHT : COORD_LIMIT;

  typedef logic [1:0]         req_type_t;
  typedef logic [1:0]         dir_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [3:0]         status_t;
  typedef logic [SIZE_W-1:0]  size_t;

  localparam req_type_t REQ_SEED = 2'd0;
  localparam req_type_t REQ_LOAD = 2'd1;
  localparam req_type_t REQ_STEP = 2'd2;

  localparam dir_t DIR_LEFT  = 2'd0;
  localparam dir_t DIR_RIGHT = 2'd1;
  localparam dir_t DIR_UP    = 2'd2;
  localparam dir_t DIR_DOWN  = 2'd3;

  localparam status_t ST_SEEDED   = 4'd0;
  localparam status_t ST_SEED_OCC = 4'd1;
  localparam status_t ST_LOADED   = 4'd2;
  localparam status_t ST_FULL     = 4'd3;
  localparam status_t ST_MOVED    = 4'd4;
  localparam status_t ST_STUCK    = 4'd5;
  localparam status_t ST_HELD     = 4'd6;
  localparam status_t ST_BAD_IDX  = 4'd7;
  localparam status_t ST_BAD_POS  = 4'd8;

  localparam size_t SIZE_MIN = 11'd3;
  localparam size_t W_MAX    = SIZE_W'(W_LIMIT);
  localparam size_t H_MAX    = SIZE_W'(H_LIMIT);

  // Clamp a size register to the range the grid supports.
  function automatic size_t sat_size(input size_t v, input size_t hi);
    size_t r;
    r = v;
    if (v < SIZE_MIN) r = SIZE_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/dla_if.sv @@
// Request and result channel interfaces of the aggregation engine.
`default_nettype none
interface dla_req_if;
  logic                valid;
  logic                ready;
  dla_pkg::req_type_t  req_type;
  dla_pkg::coord_t     pos_x;
  dla_pkg::coord_t     pos_y;
  dla_pkg::idx_t       walker_index;
  dla_pkg::dir_t       rand_dir;

  modport source (output valid, req_type, pos_x, pos_y, walker_index, rand_dir,
                  input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, walker_index, rand_dir,
                  output ready);
endinterface

interface dla_res_if;
  logic                valid;
  logic                ready;
  dla_pkg::status_t    status;
  dla_pkg::coord_t     out_x;
  dla_pkg::coord_t     out_y;
  dla_pkg::cnt_t       walkers_left;
  logic                all_stuck;

  modport source (output valid, status, out_x, out_y, walkers_left, all_stuck,
                  input ready);
  modport sink   (input valid, status, out_x, out_y, walkers_left, all_stuck,
                  output ready);
endinterface
`default_nettype wire

@@ sv/dla_walker_step.sv @@
// Diffusion-limited aggregation engine: occupancy bitmap, walker table, sequencer.
// A load or bad request goes straight to its result; a seed or step first reads the centre
// word, a step after reading its table entry; a seed or stick then marks each touched word
// by a read-modify-write. The next request can be taken once this result is offered, before
// its transfer. Reset: synchronous; a clearing pass zeroes all 32768 bitmap words, one word
// a cycle, before the first request is taken. Sizes reset to 1024.
`default_nettype none
module dla_walker_step (
  input  wire logic          clk,
  input  wire logic          rst,
  dla_req_if.sink            req,
  dla_res_if.source          res,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dla_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_WREAD  = 3'd2;
  localparam logic [2:0] S_CENTER = 3'd3;
  localparam logic [2:0] S_MREAD  = 3'd4;
  localparam logic [2:0] S_MWRITE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // Configuration
  size_t width_reg, height_reg, w_eff, h_eff;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {{(32-SIZE_W){1'b0}}, paddr[2] ? height_reg : width_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= W_MAX;
      height_reg <= H_MAX;
      w_eff      <= W_MAX;
      h_eff      <= H_MAX;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        height_reg <= pwdata[SIZE_W-1:0];
        h_eff      <= sat_size(pwdata[SIZE_W-1:0], H_MAX);
      end else begin
        width_reg <= pwdata[SIZE_W-1:0];
        w_eff     <= sat_size(pwdata[SIZE_W-1:0], W_MAX);
      end
    end
  end

  // Memories
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] map_rdata, map_wdata;
  logic [MAP_AW-1:0]    map_raddr, map_waddr;
  logic                 map_we;

  logic [ENTRY_W-1:0]   tbl_mem [MAX_WALKERS];
  logic [ENTRY_W-1:0]   tbl_rdata, tbl_wdata;
  idx_t                 tbl_raddr, tbl_waddr;
  logic                 tbl_we;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_raddr];
  end

  // Sequencer state
  logic [2:0]        state, state_next;
  logic [MAP_AW-1:0] clr_addr;
  cnt_t              count;
  req_type_t         cur_type;
  idx_t              cur_idx;
  dir_t              cur_dir;
  coord_t            wx, wy;
  logic [1:0]        mk_row;
  logic              mk_side;
  logic              mk_centre;
  status_t           res_status;
  coord_t            res_x, res_y;
  logic              res_done;

  // Request decode, valid only in S_IDLE
  logic   acc;
  logic   seed_bad, load_bad, load_full, idx_bad;
  cnt_t   cnt_m1;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign cnt_m1    = count - CNT_W'(1);
  assign seed_bad  = ({1'b0, req.pos_x} >= w_eff) || ({1'b0, req.pos_y} >= h_eff);
  assign load_bad  = (req.pos_x == '0) || ({1'b0, req.pos_x} > w_eff - SIZE_W'(2)) ||
                     (req.pos_y == '0) || ({1'b0, req.pos_y} > h_eff - SIZE_W'(2));
  assign load_full = count[CNT_W-1];
  assign idx_bad   = {1'b0, req.walker_index} >= count;

  // Centre test and move
  logic   cbit;
  logic   held;
  coord_t nx, ny;

  assign cbit = map_rdata[wx[BIT_W-1:0]];

  always_comb begin
    held = 1'b0;
    nx   = wx;
    ny   = wy;
    unique case (cur_dir)
      DIR_LEFT: begin
        held = (wx <= COORD_W'(1));
        if (!held) nx = wx - COORD_W'(1);
      end
      DIR_RIGHT: begin
        held = ({1'b0, wx} >= w_eff - SIZE_W'(2));
        if (!held) nx = wx + COORD_W'(1);
      end
      DIR_UP: begin
        held = (wy <= COORD_W'(1));
        if (!held) ny = wy - COORD_W'(1);
      end
      DIR_DOWN: begin
        held = ({1'b0, wy} >= h_eff - SIZE_W'(2));
        if (!held) ny = wy + COORD_W'(1);
      end
      default: held = 1'b0;
    endcase
  end

  // Neighbour marking: row wy-1..wy+1, word of column wx-1 then of wx+1
  logic [SIZE_W-1:0]    mrow, col_lo, col_hi;
  logic                 row_ok;
  logic [WSEL_W-1:0]    wsel0, wsel1, mword;
  logic                 two_words;
  logic [WORD_BITS-1:0] mask;
  logic [MAP_AW-1:0]    mark_addr;

  assign mrow      = {1'b0, wy} + SIZE_W'(mk_row) - SIZE_W'(1);
  assign row_ok    = mrow < h_eff;
  assign col_lo    = {1'b0, wx} - SIZE_W'(1);
  assign col_hi    = {1'b0, wx} + SIZE_W'(1);
  assign wsel0     = col_lo[SIZE_W-1] ? wx[COORD_W-1:BIT_W] : col_lo[COORD_W-1:BIT_W];
  assign wsel1     = col_hi[SIZE_W-1] ? wx[COORD_W-1:BIT_W] : col_hi[COORD_W-1:BIT_W];
  assign two_words = (wsel1 != wsel0);
  assign mword     = mk_side ? wsel1 : wsel0;
  assign mark_addr = {mrow[ROW_W-1:0], mword};

  always_comb begin
    logic [SIZE_W-1:0] col_k;
    mask = '0;
    for (int k = 0; k < 3; k++) begin
      col_k = {1'b0, wx} + SIZE_W'(k) - SIZE_W'(1);
      if (row_ok && (col_k < w_eff) && (col_k[COORD_W-1:BIT_W] == mword) &&
          !(k == 1 && mk_row == 2'd1 && !mk_centre))
        mask[col_k[BIT_W-1:0]] = 1'b1;
    end
  end

  // Memory ports
  always_comb begin
    map_we    = 1'b0;
    map_waddr = mark_addr;
    map_wdata = map_rdata | mask;
    map_raddr = mark_addr;
    tbl_we    = 1'b0;
    tbl_waddr = cur_idx;
    tbl_wdata = tbl_rdata;
    tbl_raddr = cnt_m1[IDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        map_wdata = '0;
      end
      S_IDLE: begin
        map_raddr = {req.pos_y[ROW_W-1:0], req.pos_x[COORD_W-1:BIT_W]};
        tbl_raddr = req.walker_index;
        tbl_waddr = count[IDX_W-1:0];
        tbl_wdata = {req.pos_y, req.pos_x};
        tbl_we    = acc && (req.req_type == REQ_LOAD) && !load_bad && !load_full;
      end
      S_WREAD: begin
        map_raddr = {tbl_rdata[COORD_W+ROW_W-1:COORD_W], tbl_rdata[COORD_W-1:BIT_W]};
      end
      S_CENTER: begin
        // Stick moves the last entry into the slot; a move rewrites the slot.
        if (cur_type == REQ_STEP) begin
          tbl_we    = 1'b1;
          tbl_wdata = cbit ? tbl_rdata : {ny, nx};
        end
      end
      S_MWRITE: map_we = 1'b1;
      default: map_we = 1'b0;
    endcase
  end

  // Control
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == MAP_AW'(MAP_WORDS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (acc) begin
          priority if (req.req_type == REQ_SEED && !seed_bad) state_next = S_CENTER;
          else if (req.req_type == REQ_STEP && !idx_bad)      state_next = S_WREAD;
          else                                                state_next = S_DONE;
        end
      end
      S_WREAD:  state_next = S_CENTER;
      S_CENTER: begin
        if (cbit == (cur_type == REQ_STEP)) state_next = S_MREAD;
        else                                state_next = S_DONE;
      end
      S_MREAD:  state_next = S_MWRITE;
      S_MWRITE: begin
        if (!(mk_side == 1'b0 && two_words) && mk_row == 2'd2) state_next = S_DONE;
        else                                                  state_next = S_MREAD;
      end
      S_DONE:   if (!res.valid || res.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      count     <= '0;
      res.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + MAP_AW'(1);
      if (state == S_IDLE && acc && req.req_type == REQ_LOAD && !load_bad && !load_full)
        count <= count + CNT_W'(1);
      if (state == S_CENTER && cur_type == REQ_STEP && cbit)
        count <= cnt_m1;
      if (state == S_DONE && (!res.valid || res.ready)) res.valid <= 1'b1;
      else if (res.ready)                                res.valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        cur_type  <= req.req_type;
        cur_idx   <= req.walker_index;
        cur_dir   <= req.rand_dir;
        wx        <= req.pos_x;
        wy        <= req.pos_y;
        res_x     <= req.pos_x;
        res_y     <= req.pos_y;
        res_done  <= 1'b0;
        mk_row    <= 2'd0;
        mk_side   <= 1'b0;
        mk_centre <= (req.req_type == REQ_SEED);
        unique case (req.req_type)
          REQ_SEED: res_status <= ST_BAD_POS;
          REQ_LOAD: res_status <= load_bad ? ST_BAD_POS : (load_full ? ST_FULL : ST_LOADED);
          REQ_STEP: begin
            if (idx_bad) begin
              res_status <= ST_BAD_IDX;
              res_x      <= '0;
              res_y      <= '0;
            end
          end
          default:  res_status <= ST_BAD_POS;
        endcase
      end
      S_WREAD: begin
        wx <= tbl_rdata[COORD_W-1:0];
        wy <= tbl_rdata[ENTRY_W-1:COORD_W];
      end
      S_CENTER: begin
        if (cur_type == REQ_STEP) begin
          if (cbit) begin
            res_status <= ST_STUCK;
            res_x      <= wx;
            res_y      <= wy;
            res_done   <= (count == CNT_W'(1));
          end else begin
            res_status <= held ? ST_HELD : ST_MOVED;
            res_x      <= nx;
            res_y      <= ny;
          end
        end else begin
          res_status <= cbit ? ST_SEED_OCC : ST_SEEDED;
        end
      end
      S_MWRITE: begin
        // Advance to the second word of the row, else to the next row.
        if (mk_side == 1'b0 && two_words) begin
          mk_side <= 1'b1;
        end else begin
          mk_side <= 1'b0;
          mk_row  <= mk_row + 2'd1;
        end
      end
      S_DONE: begin
        if (!res.valid || res.ready) begin
          res.status       <= res_status;
          res.out_x        <= res_x;
          res.out_y        <= res_y;
          res.walkers_left <= count;
          res.all_stuck    <= res_done;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ verif/dla_walker_step_tb.sv @@
// Self-checking testbench of the aggregation engine: request/result channels and size registers.
`timescale 1ns / 100ps
`default_nettype none
module dla_walker_step_tb;
  import dla_pkg::*;

  localparam req_type_t   REQ_UNUSED  = 2'd3;
  localparam logic [2:0]  ADDR_GRID_W = 3'd0;
  localparam logic [2:0]  ADDR_GRID_H = 3'd4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL  = 24;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    req_type_t kind;
    coord_t    px;
    coord_t    py;
    idx_t      slot;
    dir_t      dir;
  } walk_req_t;

  typedef struct packed {
    status_t status;
    coord_t  x;
    coord_t  y;
    cnt_t    left;
    logic    all_stuck;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dla_req_if req_bus ();
  dla_res_if res_bus ();

  dla_walker_step i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Predictor state: sticky bitmap, walker table, size registers.
  bit [MAX_WIDTH-1:0] sticky_rows [MAX_HEIGHT];
  coord_t             walker_col [MAX_WALKERS];
  coord_t             walker_row [MAX_WALKERS];
  int unsigned        n_walkers = 0;
  size_t              width_reg = 11'd1024;
  size_t              height_reg = 11'd1024;

  walk_result_t pending_results [$];
  int unsigned  n_errors = 0;
  int unsigned  cycle_count = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  int unsigned  rx_hold_asks = 0;
  int unsigned  rx_hold_done = 0;
  int unsigned  rx_stall = 0;

  function automatic int unsigned grid_dim(input size_t v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Mark the ring round (cx, cy), and the cell itself if asked; drop marks off the grid.
  function automatic void mark_block(input int cx, input int cy, input bit with_centre,
                                     input int w, input int h);
    int nx;
    int ny;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        nx = cx + dx;
        ny = cy + dy;
        if ((dx != 0 || dy != 0 || with_centre) && nx >= 0 && ny >= 0 && nx < w && ny < h)
          sticky_rows[ny][nx] = 1'b1;
      end
    end
  endfunction

  function automatic walk_result_t predict_outcome(input walk_req_t rq);
    walk_result_t r;
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    int unsigned  y;
    bit           held;
    w = grid_dim(width_reg, W_LIMIT);
    h = grid_dim(height_reg, H_LIMIT);
    r.status    = ST_BAD_POS;
    r.x         = rq.px;
    r.y         = rq.py;
    r.all_stuck = 1'b0;
    case (rq.kind)
      REQ_SEED: begin
        if (rq.px >= w || rq.py >= h) r.status = ST_BAD_POS;
        else if (sticky_rows[rq.py][rq.px]) r.status = ST_SEED_OCC;
        else begin
          mark_block(rq.px, rq.py, 1'b1, w, h);
          r.status = ST_SEEDED;
        end
      end
      REQ_LOAD: begin
        if (rq.px < 1 || rq.px > w - 2 || rq.py < 1 || rq.py > h - 2) r.status = ST_BAD_POS;
        else if (n_walkers >= MAX_WALKERS) r.status = ST_FULL;
        else begin
          walker_col[n_walkers] = rq.px;
          walker_row[n_walkers] = rq.py;
          n_walkers++;
          r.status = ST_LOADED;
        end
      end
      REQ_STEP: begin
        if (rq.slot >= n_walkers) begin
          r.status = ST_BAD_IDX;
          r.x      = '0;
          r.y      = '0;
        end else begin
          x = walker_col[rq.slot];
          y = walker_row[rq.slot];
          if (sticky_rows[y][x]) begin
            // Stick: mark neighbours, fill the hole with the last walker.
            mark_block(x, y, 1'b0, w, h);
            n_walkers--;
            walker_col[rq.slot] = walker_col[n_walkers];
            walker_row[rq.slot] = walker_row[n_walkers];
            r.status    = ST_STUCK;
            r.all_stuck = (n_walkers == 0);
          end else begin
            case (rq.dir)
              DIR_LEFT: begin
                held = (x <= 1);
                if (!held) x--;
              end
              DIR_RIGHT: begin
                held = (x >= w - 2);
                if (!held) x++;
              end
              DIR_UP: begin
                held = (y <= 1);
                if (!held) y--;
              end
              default: begin
                held = (y >= h - 2);
                if (!held) y++;
              end
            endcase
            walker_col[rq.slot] = coord_t'(x);
            walker_row[rq.slot] = coord_t'(y);
            r.status = held ? ST_HELD : ST_MOVED;
          end
          r.x = coord_t'(x);
          r.y = coord_t'(y);
        end
      end
      default: ;
    endcase
    r.left = cnt_t'(n_walkers);
    return r;
  endfunction

  function automatic walk_req_t make_req(input req_type_t k, input int unsigned x,
                                         input int unsigned y, input int unsigned s,
                                         input dir_t d);
    walk_req_t rq;
    rq.kind = k;
    rq.px   = coord_t'(x);
    rq.py   = coord_t'(y);
    rq.slot = idx_t'(s);
    rq.dir  = d;
    return rq;
  endfunction

  function automatic walk_req_t random_req();
    walk_req_t   rq;
    int unsigned w;
    int unsigned h;
    int unsigned pick;
    int unsigned k;
    w = grid_dim(width_reg, W_LIMIT);
    h = grid_dim(height_reg, H_LIMIT);
    rq = make_req(REQ_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, MAX_WALKERS - 1), dir_t'($urandom_range(0, 3)));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      rq.kind = REQ_SEED;
      if (pick < 4 && n_walkers > 0) begin
        // Seed under a walker so that it sticks on its next step.
        k = $urandom_range(0, n_walkers - 1);
        rq.px = walker_col[k];
        rq.py = walker_row[k];
      end else if (pick < 10) begin
        rq.px = coord_t'($urandom_range(0, w - 1));
        rq.py = coord_t'($urandom_range(0, h - 1));
      end
    end else if (pick < 32) begin
      rq.kind = REQ_LOAD;
      if (pick < 29) begin
        rq.px = coord_t'($urandom_range(1, w - 2));
        rq.py = coord_t'($urandom_range(1, h - 2));
      end
    end else if (pick < 96) begin
      if (pick < 90 && n_walkers > 0) rq.slot = idx_t'($urandom_range(0, n_walkers - 1));
    end else begin
      rq.kind = REQ_UNUSED;
    end
    return rq;
  endfunction

  // Offer one request, wait for the transfer, then record its expected result.
  task automatic send_req(input walk_req_t rq);
    int unsigned gap;
    gap = tx_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= rq.kind;
    req_bus.pos_x        <= rq.px;
    req_bus.pos_y        <= rq.py;
    req_bus.walker_index <= rq.slot;
    req_bus.rand_dir     <= rq.dir;
    do @(posedge clk); while (!req_bus.ready);
    pending_results.push_back(predict_outcome(rq));
  endtask

  task automatic wait_results_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_sizes();
    logic [31:0] rd;
    apb_read(ADDR_GRID_W, rd);
    if (rd[SIZE_W-1:0] !== width_reg) begin
      $error("grid_width: expected %0d, got %0d", width_reg, rd[SIZE_W-1:0]);
      n_errors++;
    end
    apb_read(ADDR_GRID_H, rd);
    if (rd[SIZE_W-1:0] !== height_reg) begin
      $error("grid_height: expected %0d, got %0d", height_reg, rd[SIZE_W-1:0]);
      n_errors++;
    end
  endtask

  // Only call while the engine is idle.
  task automatic set_grid_size(input int unsigned w, input int unsigned h);
    apb_write(ADDR_GRID_W, {21'($urandom()), 11'(w)});
    width_reg = 11'(w);
    apb_write(ADDR_GRID_H, {21'($urandom()), 11'(h)});
    height_reg = 11'(h);
    check_sizes();
  endtask

  task automatic test_reset_values();
    check_sizes();
  endtask

  // Full-size grid: corners, border loads, held and moved steps, sticking walkers.
  task automatic test_edges();
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_LEFT));
    send_req(make_req(REQ_UNUSED, 1023, 1023, MAX_WALKERS - 1, DIR_DOWN));
    send_req(make_req(REQ_SEED, 0, 0, 0, DIR_LEFT));
    send_req(make_req(REQ_SEED, 0, 0, 0, DIR_LEFT));
    send_req(make_req(REQ_SEED, 1023, 1023, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 0, 5, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 5, 1023, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 1023, 5, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 1, 1, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 1022, 1022, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 1, 600, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 2, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 2, DIR_RIGHT));
    send_req(make_req(REQ_STEP, 0, 0, 2, DIR_UP));
    send_req(make_req(REQ_STEP, 0, 0, 2, DIR_DOWN));
    send_req(make_req(REQ_STEP, 0, 0, 1, DIR_RIGHT));
    send_req(make_req(REQ_STEP, 0, 0, 2, DIR_RIGHT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_UP));
    send_req(make_req(REQ_SEED, 2, 600, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_DOWN));
  endtask

  // Smallest grid, reached through saturation of both registers.
  task automatic test_min_grid();
    wait_results_drained();
    set_grid_size(2, 0);
    send_req(make_req(REQ_SEED, 3, 1, 0, DIR_LEFT));
    send_req(make_req(REQ_SEED, 1, 3, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 2, 1, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 1, 1, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_RIGHT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_UP));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_DOWN));
    send_req(make_req(REQ_SEED, 2, 2, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, 0, DIR_LEFT));
  endtask

  task automatic run_random_phase(input int unsigned w, input int unsigned h,
                                  input int unsigned n_items, input bit with_hold);
    wait_results_drained();
    set_grid_size(w, h);
    tx_idle_on = ($urandom_range(0, 3) != 0);
    rx_idle_on = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n_items; i++) begin
      // Block the result side for a long stretch while requests keep coming.
      if (with_hold && i == n_items / 3) rx_hold_asks++;
      send_req(random_req());
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(16, 16, 120, 1'b1);
    run_random_phase(3, 40, 80, 1'b0);
    run_random_phase(1024, 1024, 100, 1'b1);
    run_random_phase(2047, 5, 80, 1'b0);
    run_random_phase(0, 1, 50, 1'b0);
    run_random_phase($urandom_range(4, 40), $urandom_range(4, 40), 110, 1'b0);
    run_random_phase($urandom_range(4, 64), $urandom_range(4, 64), 100, 1'b1);
  endtask

  // Fill the walker table to capacity, then hit the full and last-slot cases.
  task automatic test_table_full();
    int unsigned k;
    wait_results_drained();
    set_grid_size(1024, 1024);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (n_walkers < MAX_WALKERS)
      send_req(make_req(REQ_LOAD, $urandom_range(1, 1022), $urandom_range(1, 1022), 0,
                        DIR_LEFT));
    send_req(make_req(REQ_LOAD, 500, 500, 0, DIR_LEFT));
    send_req(make_req(REQ_LOAD, 0, 0, 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, MAX_WALKERS - 1, dir_t'($urandom_range(0, 3))));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    k = $urandom_range(0, MAX_WALKERS - 2);
    send_req(make_req(REQ_SEED, walker_col[k], walker_row[k], 0, DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, k, DIR_LEFT));
    send_req(make_req(REQ_SEED, walker_col[n_walkers - 1], walker_row[n_walkers - 1], 0,
                      DIR_LEFT));
    send_req(make_req(REQ_STEP, 0, 0, n_walkers - 1, DIR_RIGHT));
    for (int i = 0; i < 20; i++) send_req(random_req());
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else if (rx_hold_done != rx_hold_asks) begin
      rx_hold_done = rx_hold_asks;
      rx_stall = HOLD_CYCLES;
      res_bus.ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      if (rx_idle_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    walk_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: status %0d", res_bus.status);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (res_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_bus.status);
          n_errors++;
        end
        if (res_bus.out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, res_bus.out_x);
          n_errors++;
        end
        if (res_bus.out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, res_bus.out_y);
          n_errors++;
        end
        if (res_bus.walkers_left !== want.left) begin
          $error("walkers_left: expected %0d, got %0d", want.left, res_bus.walkers_left);
          n_errors++;
        end
        if (res_bus.all_stuck !== want.all_stuck) begin
          $error("all_stuck: expected %0d, got %0d", want.all_stuck, res_bus.all_stuck);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("dla_walker_step verification failed");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_SEED;
    req_bus.pos_x        = '0;
    req_bus.pos_y        = '0;
    req_bus.walker_index = '0;
    req_bus.rand_dir     = DIR_LEFT;
    res_bus.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_edges();
    test_min_grid();
    test_random_phases();
    test_table_full();

    wait_results_drained();
    if (n_errors == 0) begin
      $display("dla_walker_step verification clean");
    end else begin
      $display("dla_walker_step verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
